@@ design/imu_zero_velocity_detector_core_macros.svh @@
// assertion macros shared by the detector modules
`ifndef IMU_ZERO_VELOCITY_DETECTOR_CORE_MACROS_SVH
`define IMU_ZERO_VELOCITY_DETECTOR_CORE_MACROS_SVH

// same-cycle implication on clk, off while arst_n is low
`define IZVD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("izvd assertion failed");

// next-cycle implication on clk, off while arst_n is low
`define IZVD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("izvd assertion failed");

`endif

@@ design/izvd_pkg.sv @@
// shared types and constants of the zero-velocity detector
package izvd_pkg;

	localparam int SQ_WIDTH = 32;
	localparam logic [SQ_WIDTH-1:0] SQ_MAX = 32'hFFFF_FFFF;

	localparam int CFG_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int REASON_WIDTH = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_WIDTH-1:0] GYRO_ENTER_RESET = 32'd0;
	localparam logic [CFG_WIDTH-1:0] ACCEL_ENTER_RESET = 32'd0;
	localparam logic [CFG_WIDTH-1:0] GYRO_EXIT_RESET = 32'd3221225472;
	localparam logic [CFG_WIDTH-1:0] ACCEL_EXIT_RESET = 32'd3221225472;
	localparam logic [CFG_WIDTH-1:0] MIN_STILL_RESET = 32'd200000;
	localparam logic [CFG_WIDTH-1:0] MIN_MOTION_RESET = 32'd20000;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		CFG_GYRO_ENTER = 3'd0,
		CFG_ACCEL_ENTER = 3'd1,
		CFG_GYRO_EXIT = 3'd2,
		CFG_ACCEL_EXIT = 3'd3,
		CFG_MIN_STILL = 3'd4,
		CFG_MIN_MOTION = 3'd5
	} cfg_index_t;

	typedef enum logic [REASON_WIDTH-1:0] {
		R_BAD_SAMPLE = 4'd0,
		R_MOVING = 4'd1,
		R_ENTER_STARTED = 4'd2,
		R_ASSERTED = 4'd3,
		R_ENTER_PENDING = 4'd4,
		R_HELD = 4'd5,
		R_EXIT_STARTED = 4'd6,
		R_CLEARED = 4'd7,
		R_EXIT_PENDING = 4'd8
	} reason_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

@@ design/imu_zero_velocity_detector_core.sv @@
// top level of the imu zero-velocity detector
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_stall    time_ok time_us sample_ok gyro_* accel_*
//  out       source     out_valid / out_stall  is_still *_mag_sq *_elapsed_us reason_code
//  cfg       sink       cfg_write              cfg_index cfg_data
//
//  one sample per cycle sustained while out_stall stays low; the back end updates the dwell state on each pop
//  path from input beat to result: norm stage, fifo, state stage, output
//  samples with a bad timestamp, and backward timestamps, give no result beat
//  out_stall backs up into the fifo; in_stall rises only when the fifo is full
//  reset is asynchronous, active low, and needs no clearing pass
module imu_zero_velocity_detector_core #(
	parameter int AXIS_WIDTH = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [izvd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [izvd_pkg::CFG_WIDTH-1:0]       cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 time_ok,
	input  logic [TIME_WIDTH-1:0]                time_us,
	input  logic                                 sample_ok,
	input  logic signed [AXIS_WIDTH-1:0]         gyro_x,
	input  logic signed [AXIS_WIDTH-1:0]         gyro_y,
	input  logic signed [AXIS_WIDTH-1:0]         gyro_z,
	input  logic signed [AXIS_WIDTH-1:0]         accel_x,
	input  logic signed [AXIS_WIDTH-1:0]         accel_y,
	input  logic signed [AXIS_WIDTH-1:0]         accel_z,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 is_still,
	output logic [izvd_pkg::SQ_WIDTH-1:0]        gyro_mag_sq,
	output logic [izvd_pkg::SQ_WIDTH-1:0]        accel_mag_sq,
	output logic [TIME_WIDTH-1:0]                enter_elapsed_us,
	output logic [TIME_WIDTH-1:0]                exit_elapsed_us,
	output logic [izvd_pkg::REASON_WIDTH-1:0]    reason_code
);
	import izvd_pkg::*;

	localparam int QW = TIME_WIDTH + 2 * SQ_WIDTH + 1;

	q_stat_t         q_stat;
	logic            push;
	logic [QW-1:0]   push_data;
	logic            pop;
	logic [QW-1:0]   pop_data;

	izvd_front #(
		.AXIS_WIDTH (AXIS_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.time_ok   (time_ok),
		.time_us   (time_us),
		.sample_ok (sample_ok),
		.gyro_x    (gyro_x),
		.gyro_y    (gyro_y),
		.gyro_z    (gyro_z),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	izvd_queue #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	izvd_back #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.q_stat           (q_stat),
		.q_data           (pop_data),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.is_still         (is_still),
		.gyro_mag_sq      (gyro_mag_sq),
		.accel_mag_sq     (accel_mag_sq),
		.enter_elapsed_us (enter_elapsed_us),
		.exit_elapsed_us  (exit_elapsed_us),
		.reason_code      (reason_code)
	);

endmodule

@@ design/izvd_front.sv @@
// front end: takes samples, drops bad timestamps, forms squared norms
module izvd_front #(
	parameter int AXIS_WIDTH = 16,
	parameter int TIME_WIDTH = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            time_ok,
	input  logic [TIME_WIDTH-1:0]           time_us,
	input  logic                            sample_ok,
	input  logic signed [AXIS_WIDTH-1:0]    gyro_x,
	input  logic signed [AXIS_WIDTH-1:0]    gyro_y,
	input  logic signed [AXIS_WIDTH-1:0]    gyro_z,
	input  logic signed [AXIS_WIDTH-1:0]    accel_x,
	input  logic signed [AXIS_WIDTH-1:0]    accel_y,
	input  logic signed [AXIS_WIDTH-1:0]    accel_z,
	input  izvd_pkg::q_stat_t               q_stat,
	output logic                            push,
	output logic [TIME_WIDTH+2*izvd_pkg::SQ_WIDTH:0] push_data
);
	import izvd_pkg::*;

	localparam int PW = 2 * AXIS_WIDTH;
	localparam int SUM_W = PW + 2;

	function automatic logic [SQ_WIDTH-1:0] norm_sq(
		input logic signed [AXIS_WIDTH-1:0] x,
		input logic signed [AXIS_WIDTH-1:0] y,
		input logic signed [AXIS_WIDTH-1:0] z
	);
		logic signed [PW-1:0] xe, ye, ze;
		logic [PW-1:0] xx, yy, zz;
		logic [SUM_W-1:0] s;
		logic [63:0] s64;
		xe = PW'(x);
		ye = PW'(y);
		ze = PW'(z);
		xx = unsigned'(xe * xe);
		yy = unsigned'(ye * ye);
		zz = unsigned'(ze * ze);
		s = SUM_W'(xx) + SUM_W'(yy) + SUM_W'(zz);
		s64 = 64'(s);
		// saturate, only reachable with wide axes
		return (s64 > 64'(SQ_MAX)) ? SQ_MAX : s64[SQ_WIDTH-1:0];
	endfunction

	logic                  v_s1;
	logic                  sok_s1;
	logic [TIME_WIDTH-1:0] t_s1;
	logic [SQ_WIDTH-1:0]   g_s1;
	logic [SQ_WIDTH-1:0]   a_s1;
	logic                  s1_free;

	assign push = v_s1 && !q_stat.full;
	assign in_stall = v_s1 && q_stat.full;
	assign s1_free = !v_s1 || push;
	assign push_data = {sok_s1, t_s1, g_s1, a_s1};

	// invalid timestamps never reach the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_free) begin
			v_s1 <= in_valid && time_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_free) begin
			sok_s1 <= sample_ok;
			t_s1 <= time_us;
			g_s1 <= norm_sq(gyro_x, gyro_y, gyro_z);
			a_s1 <= norm_sq(accel_x, accel_y, accel_z);
		end
	end

endmodule

@@ design/izvd_queue.sv @@
// short fifo between the front end and the detector back end
`include "imu_zero_velocity_detector_core_macros.svh"

module izvd_queue #(
	parameter int WIDTH = 113,
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [WIDTH-1:0]   push_data,
	input  logic               pop,
	output logic [WIDTH-1:0]   pop_data,
	output izvd_pkg::q_stat_t  stat
);
	import izvd_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [IW-1:0]    wr_ptr_q;
	logic [IW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full = (count_q == CW'(DEPTH));
	assign stat.nonempty = (count_q != '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && stat.nonempty;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`IZVD_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`IZVD_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1)
	`IZVD_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1)

endmodule

@@ design/izvd_back.sv @@
// back end: dwell state, candidate tracking, result staging and config registers
`include "imu_zero_velocity_detector_core_macros.svh"

module izvd_back #(
	parameter int TIME_WIDTH = 48
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [izvd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [izvd_pkg::CFG_WIDTH-1:0]          cfg_data,
	input  izvd_pkg::q_stat_t                       q_stat,
	input  logic [TIME_WIDTH+2*izvd_pkg::SQ_WIDTH:0] q_data,
	output logic                                    pop,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    is_still,
	output logic [izvd_pkg::SQ_WIDTH-1:0]           gyro_mag_sq,
	output logic [izvd_pkg::SQ_WIDTH-1:0]           accel_mag_sq,
	output logic [TIME_WIDTH-1:0]                   enter_elapsed_us,
	output logic [TIME_WIDTH-1:0]                   exit_elapsed_us,
	output logic [izvd_pkg::REASON_WIDTH-1:0]       reason_code
);
	import izvd_pkg::*;

	function automatic logic [TIME_WIDTH-1:0] since_us(
		input logic [TIME_WIDTH-1:0] now,
		input logic [TIME_WIDTH-1:0] start
	);
		return (now >= start) ? now - start : '0;
	endfunction

	// config registers
	logic [CFG_WIDTH-1:0] gyro_enter_q, accel_enter_q, gyro_exit_q, accel_exit_q;
	logic [CFG_WIDTH-1:0] min_still_q, min_motion_q;

	// detector state
	logic                  still_q;
	logic [TIME_WIDTH-1:0] lt_q;
	logic                  ltv_q;
	logic [TIME_WIDTH-1:0] es_q;
	logic                  ev_q;
	logic [TIME_WIDTH-1:0] xs_q;
	logic                  xv_q;
	logic [SQ_WIDTH-1:0]   gsq_q;
	logic [SQ_WIDTH-1:0]   asq_q;

	// popped beat
	logic                  sok;
	logic [TIME_WIDTH-1:0] t;
	logic [SQ_WIDTH-1:0]   g;
	logic [SQ_WIDTH-1:0]   a;

	logic                  backward;
	logic                  enter_cand;
	logic                  exit_cand;
	logic                  enter_dwell_ok;
	logic                  exit_dwell_ok;
	logic [TIME_WIDTH-1:0] xs_eff;

	logic                  still_n;
	logic [TIME_WIDTH-1:0] es_n;
	logic                  ev_n;
	logic [TIME_WIDTH-1:0] xs_n;
	logic                  xv_n;
	logic [SQ_WIDTH-1:0]   gsq_n;
	logic [SQ_WIDTH-1:0]   asq_n;
	reason_t               reason_n;
	logic                  emit;

	// snapshot stage
	logic                  v_s1;
	logic                  still_s1;
	logic [SQ_WIDTH-1:0]   gsq_s1;
	logic [SQ_WIDTH-1:0]   asq_s1;
	logic [TIME_WIDTH-1:0] t_s1;
	logic [TIME_WIDTH-1:0] es_s1;
	logic                  ev_s1;
	logic [TIME_WIDTH-1:0] xs_s1;
	logic                  xv_s1;
	reason_t               reason_s1;

	// output stage
	logic                  v_s2;
	logic                  still_s2;
	logic [SQ_WIDTH-1:0]   gsq_s2;
	logic [SQ_WIDTH-1:0]   asq_s2;
	logic [TIME_WIDTH-1:0] enter_el_s2;
	logic [TIME_WIDTH-1:0] exit_el_s2;
	reason_t               reason_s2;

	logic s1_free;
	logic s2_free;

	assign s2_free = !v_s2 || !out_stall;
	assign s1_free = !v_s1 || s2_free;
	assign pop = q_stat.nonempty && s1_free;

	assign {sok, t, g, a} = q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_enter_q <= GYRO_ENTER_RESET;
			accel_enter_q <= ACCEL_ENTER_RESET;
			gyro_exit_q <= GYRO_EXIT_RESET;
			accel_exit_q <= ACCEL_EXIT_RESET;
			min_still_q <= MIN_STILL_RESET;
			min_motion_q <= MIN_MOTION_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_GYRO_ENTER: gyro_enter_q <= cfg_data;
				CFG_ACCEL_ENTER: accel_enter_q <= cfg_data;
				CFG_GYRO_EXIT: gyro_exit_q <= cfg_data;
				CFG_ACCEL_EXIT: accel_exit_q <= cfg_data;
				CFG_MIN_STILL: min_still_q <= cfg_data;
				CFG_MIN_MOTION: min_motion_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign backward = ltv_q && (t < lt_q);
	assign enter_cand = (g <= gyro_enter_q) && (a <= accel_enter_q);
	assign exit_cand = (g >= gyro_exit_q) || (a >= accel_exit_q);
	// exit dwell counts from the previous sample time
	assign xs_eff = xv_q ? xs_q : (ltv_q ? lt_q : t);
	assign enter_dwell_ok = since_us(t, es_q) >= TIME_WIDTH'(min_still_q);
	assign exit_dwell_ok = since_us(t, xs_eff) >= TIME_WIDTH'(min_motion_q);

	always_comb begin
		still_n = still_q;
		es_n = es_q;
		ev_n = ev_q;
		xs_n = xs_q;
		xv_n = xv_q;
		gsq_n = gsq_q;
		asq_n = asq_q;
		reason_n = R_BAD_SAMPLE;
		emit = 1'b0;
		if (backward) begin
			ev_n = 1'b0;
			xv_n = 1'b0;
		end else begin
			emit = 1'b1;
			if (sok) begin
				gsq_n = g;
				asq_n = a;
				if (!still_q) begin
					if (!enter_cand) begin
						ev_n = 1'b0;
						reason_n = R_MOVING;
					end else if (!ev_q) begin
						es_n = t;
						ev_n = 1'b1;
						reason_n = R_ENTER_STARTED;
					end else if (enter_dwell_ok) begin
						still_n = 1'b1;
						ev_n = 1'b0;
						xv_n = 1'b0;
						reason_n = R_ASSERTED;
					end else begin
						reason_n = R_ENTER_PENDING;
					end
				end else begin
					if (!exit_cand) begin
						xv_n = 1'b0;
						reason_n = R_HELD;
					end else begin
						xs_n = xs_eff;
						xv_n = 1'b1;
						if (exit_dwell_ok) begin
							still_n = 1'b0;
							ev_n = 1'b0;
							xv_n = 1'b0;
							reason_n = R_CLEARED;
						end else if (ltv_q && (lt_q == xs_eff)) begin
							reason_n = R_EXIT_STARTED;
						end else begin
							reason_n = R_EXIT_PENDING;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q <= 1'b0;
			lt_q <= '0;
			ltv_q <= 1'b0;
			es_q <= '0;
			ev_q <= 1'b0;
			xs_q <= '0;
			xv_q <= 1'b0;
			gsq_q <= '0;
			asq_q <= '0;
		end else if (pop) begin
			still_q <= still_n;
			if (!backward) begin
				lt_q <= t;
			end
			ltv_q <= ltv_q || !backward;
			es_q <= es_n;
			ev_q <= ev_n;
			xs_q <= xs_n;
			xv_q <= xv_n;
			gsq_q <= gsq_n;
			asq_q <= asq_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_free) begin
				v_s1 <= pop && emit;
			end
			if (s2_free) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			still_s1 <= still_n;
			gsq_s1 <= gsq_n;
			asq_s1 <= asq_n;
			t_s1 <= t;
			es_s1 <= es_n;
			ev_s1 <= ev_n;
			xs_s1 <= xs_n;
			xv_s1 <= xv_n;
			reason_s1 <= reason_n;
		end
		if (v_s1 && s2_free) begin
			still_s2 <= still_s1;
			gsq_s2 <= gsq_s1;
			asq_s2 <= asq_s1;
			enter_el_s2 <= ev_s1 ? since_us(t_s1, es_s1) : '0;
			exit_el_s2 <= xv_s1 ? since_us(t_s1, xs_s1) : '0;
			reason_s2 <= reason_s1;
		end
	end

	assign out_valid = v_s2;
	assign is_still = still_s2;
	assign gyro_mag_sq = gsq_s2;
	assign accel_mag_sq = asq_s2;
	assign enter_elapsed_us = enter_el_s2;
	assign exit_elapsed_us = exit_el_s2;
	assign reason_code = reason_s2;

	`IZVD_ASSERT_NOW(a_rise_is_assert, $rose(still_q), v_s1 && (reason_s1 == R_ASSERTED))
	`IZVD_ASSERT_NOW(a_fall_is_clear, $fell(still_q), v_s1 && (reason_s1 == R_CLEARED))
	`IZVD_ASSERT_NOW(a_enter_start_time, v_s1 && (reason_s1 == R_ENTER_STARTED),
		ev_s1 && (es_s1 == t_s1))

endmodule
